### rtl/cicp_pkg.sv
// ----------------------------------------------------------------------------
// cicp_pkg
// Types, codes and helper functions shared by the cascaded controller pair.
// ----------------------------------------------------------------------------
package cicp_pkg;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [2:0] {
      CMD_CMD_WRITE  = 3'd0,
      CMD_DATA_WRITE = 3'd1,
      CMD_CMD_READ   = 3'd2,
      CMD_DATA_READ  = 3'd3,
      CMD_LINE       = 3'd4,
      CMD_ACK        = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_WARN    = 2'd1,
      ST_REJECT  = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      STEP_ICW1  = 3'd0,
      STEP_ICW2  = 3'd1,
      STEP_ICW3  = 3'd2,
      STEP_ICW4  = 3'd3,
      STEP_READY = 3'd4
   } step_type;

   // OCW2 select field (bits 7:5)
   localparam logic [2:0] OCW2_EOI       = 3'd1;
   localparam logic [2:0] OCW2_SPEC_EOI  = 3'd3;
   localparam logic [2:0] OCW2_ROT_EOI   = 3'd5;
   localparam logic [2:0] OCW2_SET_PRIO  = 3'd6;
   localparam logic [2:0] OCW2_ROT_SPEC  = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_MASTER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_SLAVE  = 2'd1;

   localparam logic [7:0] ICW1_FLAG        = 8'h10;
   localparam logic [7:0] ICW1_CHECK_MASK  = 8'hE3;
   localparam logic [7:0] ICW1_EXPECT      = 8'h01;
   localparam logic [7:0] ICW3_MASTER      = 8'h04;
   localparam logic [7:0] ICW3_SLAVE       = 8'h02;
   localparam logic [7:0] ICW4_CHECK_MASK  = 8'hED;
   localparam logic [7:0] ICW4_EXPECT      = 8'h01;
   localparam logic [7:0] OCW3_SMM         = 8'h60;
   localparam logic [7:0] EDGE_ONLY_MASTER = 8'h03;
   localparam logic [7:0] EDGE_ONLY_SLAVE  = 8'h21;

   localparam logic [2:0] CASCADE_LINE  = 3'd2;
   localparam logic [3:0] CASCADE_IRQ   = 4'd2;
   localparam logic [2:0] SPURIOUS_LINE = 3'd7;

   typedef struct packed {
      step_type   step;
      logic [7:0] request;
      logic [7:0] service;
      logic [7:0] mask;
      logic [7:0] levels;
      logic [4:0] vector_high;
      logic [2:0] base;
      logic [2:0] chosen;
      logic       out;
      logic       smm;
      logic       ris;
   } chip_state_type;

   localparam chip_state_type CHIP_RESET = '{
      step: STEP_ICW1, request: 8'h00, service: 8'h00, mask: 8'h00,
      levels: 8'h00, vector_high: 5'd0, base: 3'd0, chosen: 3'd0,
      out: 1'b0, smm: 1'b0, ris: 1'b0
   };

   typedef struct packed {
      logic [2:0] command;
      logic       chip;
      logic [7:0] write_byte;
      logic [3:0] irq_line;
      logic       level;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       intr;
      status_type status;
   } rsp_item_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             data;
   } csr_write_type;

   typedef struct packed {
      logic       found;
      logic [2:0] idx;
   } pick_type;

   // out[k] = v[(base + k) mod 8]
   function automatic logic [7:0] rotr8(logic [7:0] v, logic [2:0] base);
      logic [15:0] w;
      w = {v, v} >> base;
      return w[7:0];
   endfunction

   function automatic pick_type first_one8(logic [7:0] v);
      pick_type p;
      p = '{found: 1'b0, idx: 3'd0};
      for (int k = 7; k >= 0; k--) begin
         if (v[k]) begin
            p.found = 1'b1;
            p.idx   = 3'(k);
         end
      end
      return p;
   endfunction

   function automatic chip_state_type set_line(chip_state_type s, logic [7:0] lmask,
                                               logic [2:0] pos, logic lvl);
      chip_state_type r;
      logic [7:0]     m;
      r = s;
      m = 8'h01 << pos;
      if (lvl) begin
         // edge lines latch on the rising level only
         if ((lmask & m) != 8'h00 || (s.levels & m) == 8'h00) r.request = s.request | m;
         r.levels = s.levels | m;
      end else begin
         r.levels = s.levels & ~m;
      end
      return r;
   endfunction

   function automatic chip_state_type grant(chip_state_type s, logic [2:0] ln);
      chip_state_type r;
      r = s;
      r.request[ln] = 1'b0;
      r.service[ln] = 1'b1;
      return r;
   endfunction

endpackage

### rtl/cascaded_interrupt_controller_pair.sv
// ----------------------------------------------------------------------------
// cascaded_interrupt_controller_pair
// Master and slave interrupt controllers, slave cascaded on master line 2.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per access: port write, register read, line
//   change or interrupt acknowledge. It is taken when req_valid is high and
//   req_stall low. Every word gives exactly one rsp_* word: read data or
//   vector, the master interrupt output after the access, and a status code.
//   csr_* writes the two level-trigger masks; csr_ready is high while no
//   access sits in the input register. Write them only when the block is idle.
//   An accepted word goes to the input register, then to the result register on rsp_*.
//   Throughput: one word per cycle while rsp_stall is low; the input register
//   feeds a single pass of priority encoders into the result register.
//   When rsp_stall is high the result register holds, the input register
//   takes one more word, and then req_stall rises.
//   Reset (synchronous, active high) puts both controllers back to waiting
//   for ICW1 with all request, in-service and mask bits clear.
// ----------------------------------------------------------------------------
module cascaded_interrupt_controller_pair (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_command,
   input  logic       req_chip,
   input  logic [7:0] req_write_byte,
   input  logic [3:0] req_irq_line,
   input  logic       req_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_intr,
   output logic [1:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   import cicp_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff, s1_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   rsp_item_type  result;
   csr_write_type csr;
   logic          advance;
   logic          accept;

   assign advance   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = ~s1_valid_ff;

   assign csr = '{we: csr_valid & csr_ready, index: CSR_INDEX_W'(csr_index), data: csr_data};

   always_comb begin
      s1_valid_in  = accept | (s1_valid_ff & ~advance);
      s1_item_in   = s1_item_ff;
      if (accept) begin
         s1_item_in = '{command: req_command, chip: req_chip, write_byte: req_write_byte,
                        irq_line: req_irq_line, level: req_level};
      end
      rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   end

   cicp_state u_state (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (s1_item_ff),
      .csr       (csr),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (advance) rsp_item_ff <= result;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_item_ff.read_byte;
   assign rsp_intr      = rsp_item_ff.intr;
   assign rsp_status    = rsp_item_ff.status;

endmodule

### rtl/cicp_resolve.sv
// ----------------------------------------------------------------------------
// cicp_resolve
// Priority resolution of one controller: folds level lines into the request
// bits and picks the line that drives the chip output, rotated priority.
// ----------------------------------------------------------------------------
module cicp_resolve (
   input  cicp_pkg::chip_state_type st_in,
   input  logic [7:0]               level_mask,
   output cicp_pkg::chip_state_type st_out
);
   import cicp_pkg::*;

   logic [7:0] req_eff;
   logic [7:0] pend;
   logic [7:0] stop_v;
   pick_type   pick;
   logic [2:0] line;
   logic       hit;

   always_comb begin
      req_eff = st_in.request | (level_mask & st_in.levels);
      pend    = req_eff & ~st_in.mask & ~st_in.service;
      // fully nested: an in-service line blocks lower ones unless special mask
      stop_v  = st_in.smm ? pend : (st_in.service | (req_eff & ~st_in.mask));
      pick    = first_one8(rotr8(stop_v, st_in.base));
      line    = st_in.base + pick.idx;
      hit     = pick.found & pend[line];

      st_out         = st_in;
      st_out.request = req_eff;
      st_out.out     = hit;
      if (hit) st_out.chosen = line;
   end

endmodule

### rtl/cicp_state.sv
// ----------------------------------------------------------------------------
// cicp_state
// Register state of both controllers. Applies one item or one register
// write per cycle, then re-evaluates slave, cascade line and master.
// ----------------------------------------------------------------------------
module cicp_state (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_fire,
   input  cicp_pkg::req_item_type  item,
   input  cicp_pkg::csr_write_type csr,
   output cicp_pkg::rsp_item_type  result
);
   import cicp_pkg::*;

   chip_state_type master_ff, slave_ff;
   chip_state_type master_in, slave_in;
   logic [7:0]     lm_master_ff, lm_slave_ff;
   logic [7:0]     lm_master_in, lm_slave_in;

   chip_state_type cur, upd, master_op, slave_op, master_mid;
   pick_type       eoi_pick;
   logic [2:0]     eoi_line;
   logic           wr_sel;
   logic [7:0]     rd;
   status_type     st;
   logic [7:0]     d;

   always_comb begin
      lm_master_in = lm_master_ff;
      lm_slave_in  = lm_slave_ff;
      if (csr.we && csr.index == REG_LEVEL_MASTER) lm_master_in = csr.data & ~EDGE_ONLY_MASTER;
      if (csr.we && csr.index == REG_LEVEL_SLAVE)  lm_slave_in  = csr.data & ~EDGE_ONLY_SLAVE;
   end

   always_comb begin
      d         = item.write_byte;
      cur       = item.chip ? slave_ff : master_ff;
      upd       = cur;
      master_op = master_ff;
      slave_op  = slave_ff;
      wr_sel    = 1'b0;
      rd        = 8'h00;
      st        = ST_OK;
      eoi_pick  = first_one8(rotr8(cur.service, cur.base));
      eoi_line  = cur.base + eoi_pick.idx;

      if (item_fire) begin
         case (item.command)
            CMD_CMD_WRITE: begin
               wr_sel = 1'b1;
               if ((d & ICW1_FLAG) != 8'h00) begin
                  if (cur.step != STEP_ICW1) st = ST_WARN;
                  if ((d & ICW1_CHECK_MASK) != ICW1_EXPECT) st = ST_WARN;
                  upd.step = STEP_ICW2;
               end else if (cur.step != STEP_READY) begin
                  st = ST_REJECT;
               end else if (!d[3]) begin
                  case (d[7:5])
                     OCW2_EOI: begin
                        if (eoi_pick.found) upd.service[eoi_line] = 1'b0;
                     end
                     OCW2_SPEC_EOI: upd.service[d[2:0]] = 1'b0;
                     OCW2_ROT_EOI: begin
                        if (eoi_pick.found) begin
                           upd.service[eoi_line] = 1'b0;
                           upd.base              = eoi_line + 3'd1;
                        end
                     end
                     OCW2_SET_PRIO, OCW2_ROT_SPEC: st = ST_IGNORED;
                     default: ;
                  endcase
               end else begin
                  upd.smm = ((d & OCW3_SMM) == OCW3_SMM);
                  if (d[1]) upd.ris = d[0];
               end
            end
            CMD_DATA_WRITE: begin
               wr_sel = 1'b1;
               case (cur.step)
                  STEP_ICW2: begin
                     upd.vector_high = d[7:3];
                     if (d[2:0] != 3'd0) st = ST_WARN;
                     upd.step = STEP_ICW3;
                  end
                  STEP_ICW3: begin
                     if (d != (item.chip ? ICW3_SLAVE : ICW3_MASTER)) st = ST_WARN;
                     upd.step = STEP_ICW4;
                  end
                  STEP_ICW4: begin
                     // special fully nested or automatic EOI
                     if (d[4] || d[1]) begin
                        st = ST_IGNORED;
                     end else begin
                        if ((d & ICW4_CHECK_MASK) != ICW4_EXPECT) st = ST_WARN;
                        upd.mask = 8'h00;
                        upd.base = 3'd0;
                        upd.ris  = 1'b0;
                        upd.step = STEP_READY;
                     end
                  end
                  STEP_READY: upd.mask = d;
                  default: st = ST_REJECT;
               endcase
            end
            CMD_CMD_READ: rd = cur.ris ? cur.service : cur.request;
            CMD_DATA_READ: rd = cur.mask;
            CMD_LINE: begin
               if (item.irq_line == CASCADE_IRQ) begin
                  st = ST_REJECT;
               end else if (item.irq_line[3]) begin
                  slave_op = set_line(slave_ff, lm_slave_ff, item.irq_line[2:0], item.level);
               end else begin
                  master_op = set_line(master_ff, lm_master_ff, item.irq_line[2:0], item.level);
               end
            end
            CMD_ACK: begin
               if (!master_ff.out) begin
                  rd = {master_ff.vector_high, SPURIOUS_LINE};
               end else if (master_ff.chosen == CASCADE_LINE) begin
                  master_op = grant(master_ff, CASCADE_LINE);
                  if (slave_ff.out) begin
                     slave_op = grant(slave_ff, slave_ff.chosen);
                     rd       = {slave_ff.vector_high, slave_ff.chosen};
                  end else begin
                     rd = {slave_ff.vector_high, SPURIOUS_LINE};
                  end
               end else begin
                  master_op = grant(master_ff, master_ff.chosen);
                  rd        = {master_ff.vector_high, master_ff.chosen};
               end
            end
            default: st = ST_REJECT;
         endcase
      end

      if (wr_sel) begin
         if (item.chip) slave_op = upd;
         else master_op = upd;
      end
   end

   cicp_resolve u_resolve_slave (
      .st_in      (slave_op),
      .level_mask (lm_slave_in),
      .st_out     (slave_in)
   );

   // slave output feeds master line 2
   assign master_mid = set_line(master_op, lm_master_in, CASCADE_LINE, slave_in.out);

   cicp_resolve u_resolve_master (
      .st_in      (master_mid),
      .level_mask (lm_master_in),
      .st_out     (master_in)
   );

   assign result = '{read_byte: rd, intr: master_in.out, status: st};

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= CHIP_RESET;
         slave_ff     <= CHIP_RESET;
         lm_master_ff <= 8'h00;
         lm_slave_ff  <= 8'h00;
      end else if (item_fire || csr.we) begin
         master_ff    <= master_in;
         slave_ff     <= slave_in;
         lm_master_ff <= lm_master_in;
         lm_slave_ff  <= lm_slave_in;
      end
   end

   a_master_out_not_in_service: assert property (@(posedge clock) disable iff (reset)
      master_ff.out |-> !master_ff.service[master_ff.chosen])
      else $error("master output points at an in-service line");

   a_slave_out_not_in_service: assert property (@(posedge clock) disable iff (reset)
      slave_ff.out |-> !slave_ff.service[slave_ff.chosen])
      else $error("slave output points at an in-service line");

   a_cascade_tracks_slave: assert property (@(posedge clock) disable iff (reset)
      master_ff.levels[CASCADE_LINE] == slave_ff.out)
      else $error("cascade line level differs from slave output");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !(item_fire || csr.we) |=> $stable(master_ff) && $stable(slave_ff))
      else $error("controller state changed without an item or register write");

   a_spurious_ack_no_change: assert property (@(posedge clock) disable iff (reset)
      item_fire && item.command == CMD_ACK && !master_ff.out
      |=> $stable(master_ff.service) && $stable(slave_ff.service))
      else $error("spurious acknowledge changed in-service bits");

endmodule
